@@ design/pcra_pkg.sv @@
// Shared types, constants and widths for the PWM capture ASCII report block.
// Used by every module of the block and by its checker; depends on nothing.
package pcra_pkg;

	// Sizing
	localparam int MAX_DIGITS  = 10;
	localparam int COUNT_WIDTH = 16;
	localparam int CLOCK_W     = 28;
	localparam int DIV_W       = CLOCK_W;
	localparam int DIV_STEP_W  = $clog2(DIV_W);
	localparam int DUTY_W      = 7;
	localparam int DUTY_NUM_W  = COUNT_WIDTH + DUTY_W;
	localparam int DIGIT_W     = 4;
	localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
	localparam int DIG_CNT_W   = $clog2(MAX_DIGITS + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Divide by ten through a reciprocal: exact for dividends below 2^32
	localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;
	localparam int          PROD_W      = DIV_W + 32;

	// Constants
	localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = CLOCK_W'(72000000);
	localparam logic [DUTY_W-1:0]  DUTY_FULL      = DUTY_W'(100);
	localparam logic [7:0]         DIGIT_BASE     = 8'd48;
	localparam logic [7:0]         NEWLINE_CHAR   = 8'd10;
	localparam logic               KIND_FREQ      = 1'b0;
	localparam logic               KIND_DUTY      = 1'b1;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] period_count;
		logic [COUNT_WIDTH-1:0] high_count;
	} capture_word_t;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       value_kind;
		logic       last_byte;
	} report_word_t;

	// One measured capture, handed from front to back
	typedef struct packed {
		logic [DIV_W-1:0]  freq;
		logic [DUTY_W-1:0] duty;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_FREQ,
		F_DUTY,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_EMIT,
		B_NL
	} back_state_t;

endpackage

@@ design/pcra_front.sv @@
// Front end: takes capture words, drops zero periods, divides for frequency and duty.
// Holds the clock_hz register and a shared restoring divider; uses pcra_pkg.
module pcra_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [pcra_pkg::CLOCK_W-1:0] cfg_data,
	input  logic                     capture_valid,
	output logic                     capture_ready,
	input  pcra_pkg::capture_word_t  capture,
	output logic                     push_valid,
	input  logic                     push_ready,
	output pcra_pkg::job_t           push_data
);

	pcra_pkg::front_state_t state_q, state_d;

	logic [pcra_pkg::CLOCK_W-1:0]    clock_hz_q;
	logic [pcra_pkg::COUNT_WIDTH-1:0] den_q;
	logic [pcra_pkg::COUNT_WIDTH-1:0] rem_q;
	logic [pcra_pkg::DIV_W-1:0]      num_q;
	logic [pcra_pkg::DIV_STEP_W-1:0] step_q;
	logic [pcra_pkg::DUTY_NUM_W-1:0] duty_num_q;
	logic                            sat_q;
	logic [pcra_pkg::DIV_W-1:0]      freq_q;
	logic [pcra_pkg::DUTY_W-1:0]     duty_q;

	logic [pcra_pkg::COUNT_WIDTH:0]  shifted;
	logic [pcra_pkg::COUNT_WIDTH:0]  diff;
	logic                            ge;
	logic [pcra_pkg::COUNT_WIDTH-1:0] rem_d;
	logic [pcra_pkg::DIV_W-1:0]      quo_d;
	logic                            last_step;
	logic                            accept;
	logic                            start;

	// One restoring division step: one quotient bit a cycle
	always_comb begin
		shifted   = {rem_q, num_q[pcra_pkg::DIV_W-1]};
		diff      = shifted - {1'b0, den_q};
		ge        = (shifted >= {1'b0, den_q});
		rem_d     = ge ? diff[pcra_pkg::COUNT_WIDTH-1:0] : shifted[pcra_pkg::COUNT_WIDTH-1:0];
		quo_d     = {num_q[pcra_pkg::DIV_W-2:0], ge};
		last_step = (step_q == pcra_pkg::DIV_STEP_W'(pcra_pkg::DIV_W - 1));
	end

	assign capture_ready = (state_q == pcra_pkg::F_IDLE);
	assign accept        = capture_valid && capture_ready;
	assign start         = accept && (capture.period_count != '0);
	assign push_valid    = (state_q == pcra_pkg::F_PUSH);
	assign push_data     = '{freq: freq_q, duty: duty_q};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcra_pkg::F_IDLE: begin
				if (start) state_d = pcra_pkg::F_FREQ;
			end
			pcra_pkg::F_FREQ: begin
				if (last_step) state_d = sat_q ? pcra_pkg::F_PUSH : pcra_pkg::F_DUTY;
			end
			pcra_pkg::F_DUTY: begin
				if (last_step) state_d = pcra_pkg::F_PUSH;
			end
			pcra_pkg::F_PUSH: begin
				if (push_ready) state_d = pcra_pkg::F_IDLE;
			end
			default: state_d = pcra_pkg::F_IDLE;
		endcase
	end

	// State and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pcra_pkg::F_IDLE;
			clock_hz_q <= pcra_pkg::CLOCK_HZ_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) clock_hz_q <= cfg_data;
		end
	end

	// Divider operands and results
	always_ff @(posedge clk) begin
		case (state_q)
			pcra_pkg::F_IDLE: begin
				if (start) begin
					den_q      <= capture.period_count;
					num_q      <= clock_hz_q;
					rem_q      <= '0;
					step_q     <= '0;
					duty_num_q <= pcra_pkg::DUTY_NUM_W'(capture.high_count)
						* pcra_pkg::DUTY_NUM_W'(pcra_pkg::DUTY_FULL);
					sat_q      <= (capture.high_count >= capture.period_count);
				end
			end
			pcra_pkg::F_FREQ: begin
				// Reload the divider for the duty, or advance one step
				if (last_step && !sat_q) begin
					num_q  <= pcra_pkg::DIV_W'(duty_num_q);
					rem_q  <= '0;
					step_q <= '0;
				end else begin
					rem_q  <= rem_d;
					num_q  <= quo_d;
					step_q <= step_q + 1'b1;
				end
				if (last_step) begin
					freq_q <= quo_d;
					if (sat_q) duty_q <= pcra_pkg::DUTY_FULL;
				end
			end
			pcra_pkg::F_DUTY: begin
				rem_q  <= rem_d;
				num_q  <= quo_d;
				step_q <= step_q + 1'b1;
				if (last_step) duty_q <= quo_d[pcra_pkg::DUTY_W-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/pcra_queue.sv @@
// Short job queue between front and back ends of the report block.
// Holds measured captures so each side stalls on its own; uses pcra_pkg.
module pcra_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  pcra_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output pcra_pkg::job_t pop_data
);

	pcra_pkg::job_t                mem_q [pcra_pkg::QUEUE_DEPTH];
	logic [pcra_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [pcra_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [pcra_pkg::QCNT_W-1:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = (count_q != pcra_pkg::QCNT_W'(pcra_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == pcra_pkg::QPTR_W'(pcra_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == pcra_pkg::QPTR_W'(pcra_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ design/pcra_back.sv @@
// Back end: turns each queued capture into ASCII decimal digits and newlines.
// Holds the digit buffer and the output register; uses pcra_pkg.
module pcra_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  pcra_pkg::job_t         pop_data,
	output logic                   report_valid,
	input  logic                   report_ready,
	output pcra_pkg::report_word_t report
);

	pcra_pkg::back_state_t state_q, state_d;

	logic [pcra_pkg::DIV_W-1:0]     val_q;
	logic [pcra_pkg::DUTY_W-1:0]    duty_hold_q;
	logic                           kind_q;
	logic [pcra_pkg::DIG_CNT_W-1:0] cnt_q;
	logic [pcra_pkg::DIG_IDX_W-1:0] rd_idx_q;
	logic [pcra_pkg::DIGIT_W-1:0]   digit_buf_q [pcra_pkg::MAX_DIGITS];
	logic                           report_valid_q;
	pcra_pkg::report_word_t         report_q;

	logic [pcra_pkg::PROD_W-1:0]    prod;
	logic [pcra_pkg::DIV_W-1:0]     quo;
	logic [pcra_pkg::DIV_W-1:0]     quo10;
	logic [pcra_pkg::DIGIT_W-1:0]   digit;
	logic                           conv_done;
	logic                           emitting;
	logic                           load;
	logic                           pop;
	pcra_pkg::report_word_t         byte_d;

	// Split off the lowest decimal digit through the reciprocal of ten
	always_comb begin
		prod      = pcra_pkg::PROD_W'(val_q) * pcra_pkg::PROD_W'(pcra_pkg::RECIP_10);
		quo       = pcra_pkg::DIV_W'(prod >> pcra_pkg::RECIP_SHIFT);
		quo10     = (quo << 3) + (quo << 1);
		digit     = pcra_pkg::DIGIT_W'(val_q - quo10);
		conv_done = (quo == '0) || (cnt_q == pcra_pkg::DIG_CNT_W'(pcra_pkg::MAX_DIGITS - 1));
	end

	assign pop_ready = (state_q == pcra_pkg::B_IDLE);
	assign pop       = pop_valid && pop_ready;
	assign emitting  = (state_q == pcra_pkg::B_EMIT) || (state_q == pcra_pkg::B_NL);
	assign load      = emitting && (!report_valid_q || report_ready);

	// Byte to send next
	always_comb begin
		byte_d.value_kind = kind_q;
		if (state_q == pcra_pkg::B_NL) begin
			byte_d.ascii_char = pcra_pkg::NEWLINE_CHAR;
			byte_d.last_byte  = (kind_q == pcra_pkg::KIND_DUTY);
		end else begin
			byte_d.ascii_char = pcra_pkg::DIGIT_BASE + 8'(digit_buf_q[rd_idx_q]);
			byte_d.last_byte  = 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcra_pkg::B_IDLE: begin
				if (pop) state_d = pcra_pkg::B_CONV;
			end
			pcra_pkg::B_CONV: begin
				if (conv_done) state_d = pcra_pkg::B_EMIT;
			end
			pcra_pkg::B_EMIT: begin
				if (load && (rd_idx_q == '0)) state_d = pcra_pkg::B_NL;
			end
			pcra_pkg::B_NL: begin
				if (load) begin
					state_d = (kind_q == pcra_pkg::KIND_FREQ) ? pcra_pkg::B_CONV
						: pcra_pkg::B_IDLE;
				end
			end
			default: state_d = pcra_pkg::B_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pcra_pkg::B_IDLE;
			report_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				report_valid_q <= 1'b1;
			end else if (report_ready) begin
				report_valid_q <= 1'b0;
			end
		end
	end

	// Digit conversion and emission datapath
	always_ff @(posedge clk) begin
		if (load) report_q <= byte_d;
		case (state_q)
			pcra_pkg::B_IDLE: begin
				if (pop) begin
					val_q       <= pop_data.freq;
					duty_hold_q <= pop_data.duty;
					kind_q      <= pcra_pkg::KIND_FREQ;
					cnt_q       <= '0;
				end
			end
			pcra_pkg::B_CONV: begin
				digit_buf_q[cnt_q[pcra_pkg::DIG_IDX_W-1:0]] <= digit;
				val_q    <= quo;
				cnt_q    <= cnt_q + 1'b1;
				rd_idx_q <= cnt_q[pcra_pkg::DIG_IDX_W-1:0];
			end
			pcra_pkg::B_EMIT: begin
				if (load && (rd_idx_q != '0)) rd_idx_q <= rd_idx_q - 1'b1;
			end
			pcra_pkg::B_NL: begin
				if (load && (kind_q == pcra_pkg::KIND_FREQ)) begin
					val_q  <= pcra_pkg::DIV_W'(duty_hold_q);
					kind_q <= pcra_pkg::KIND_DUTY;
					cnt_q  <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign report_valid = report_valid_q;
	assign report       = report_q;

endmodule

@@ design/pwm_capture_report_ascii_unit.sv @@
// Top level of the PWM capture ASCII report block.
// Joins pcra_front, pcra_queue and pcra_back; uses pcra_pkg.
//
// Usage
//  - capture channel (valid/ready): one word per PWM capture, carrying the
//    period and high-time counts. A word with a zero period is taken and dropped.
//  - report channel (valid/ready): one word per output byte: the frequency in
//    hertz as decimal digits and a newline, then the duty percent the same way.
//    last_byte marks the final newline of a capture's report.
//  - cfg_we/cfg_data write clock_hz, the timer clock.
//  - Front end: the restoring divider works out the frequency, then the duty
//    unless high time reaches the period, when the duty is 100 and the second
//    division is skipped. The shared one-bit-a-cycle divider sets the capture
//    rate.
//  - Back end: per value, it converts one digit per cycle, then sends one byte
//    per cycle unless the receiver stalls; up to 14 bytes per capture.
//  - A two-word queue between the ends lets the divider keep working while
//    bytes wait on a stalled receiver; a stall holds the output register and
//    backs up through the queue to capture_ready.
//  - Reset clears all control state and sets clock_hz to 72 MHz.
module pwm_capture_report_ascii_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pcra_pkg::CLOCK_W-1:0] cfg_data,
	input  logic                         capture_valid,
	output logic                         capture_ready,
	input  pcra_pkg::capture_word_t      capture,
	output logic                         report_valid,
	input  logic                         report_ready,
	output pcra_pkg::report_word_t       report
);

	logic           push_valid;
	logic           push_ready;
	pcra_pkg::job_t push_data;
	logic           pop_valid;
	logic           pop_ready;
	pcra_pkg::job_t pop_data;

	// Measure
	pcra_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.capture_valid (capture_valid),
		.capture_ready (capture_ready),
		.capture       (capture),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	// Buffer measured captures
	pcra_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Format and send
	pcra_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report)
	);

endmodule

@@ design/pcra_checker.sv @@
// Port-level checks for the PWM capture ASCII report block, bound to its top level.
// Watches the capture and report channels only; uses pcra_pkg.
module pcra_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   capture_valid,
	input logic                   capture_ready,
	input pcra_pkg::capture_word_t capture,
	input logic                   report_valid,
	input logic                   report_ready,
	input pcra_pkg::report_word_t report
);

	// Hold a stalled report word
	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> report_valid && $stable(report))
		else $error("report word changed or dropped while stalled");

	// Send only digits and newlines
	a_report_chars: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |->
			(report.ascii_char >= pcra_pkg::DIGIT_BASE
				&& report.ascii_char <= pcra_pkg::DIGIT_BASE + 8'd9)
			|| report.ascii_char == pcra_pkg::NEWLINE_CHAR)
		else $error("report byte is neither a digit nor a newline");

	// Mark only the duty newline as last
	a_last_on_duty_nl: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report.last_byte |->
			report.ascii_char == pcra_pkg::NEWLINE_CHAR
			&& report.value_kind == pcra_pkg::KIND_DUTY)
		else $error("last byte is not the duty newline");

	// Busy after taking a capture with a non-zero period
	a_busy_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		capture_valid && capture_ready && capture.period_count != '0 |=> !capture_ready)
		else $error("capture accepted again before division");

endmodule

bind pwm_capture_report_ascii_unit pcra_checker u_pcra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.capture_valid (capture_valid),
	.capture_ready (capture_ready),
	.capture       (capture),
	.report_valid  (report_valid),
	.report_ready  (report_ready),
	.report        (report)
);

@@ tb/tb_pwm_capture_report_ascii_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pwm_capture_report_ascii_unit: capture words in, report words out.
// Expects bytes from its clock_hz copy or typed table rows; depends on pcra_pkg and the block.
module tb_pwm_capture_report_ascii_unit;

	localparam int SETTLE_CYCLES = 120;
	localparam int PHASE_ITEMS   = 21;
	localparam int DRAIN_POINT   = 12;
	localparam int N_DIRECTED    = 22;
	localparam int N_PHASES      = 7;

	typedef enum logic [1:0] {
		CHECK_PREDICT,
		CHECK_TYPED,
		CHECK_SILENT
	} check_mode_t;

	// One row of the directed table; freq and duty hold only for typed rows
	typedef struct packed {
		check_mode_t                      mode;
		logic [pcra_pkg::CLOCK_W-1:0]     clock_hz;
		logic [pcra_pkg::COUNT_WIDTH-1:0] period;
		logic [pcra_pkg::COUNT_WIDTH-1:0] high;
		logic [31:0]                      freq;
		logic [31:0]                      duty;
	} capture_case_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [pcra_pkg::CLOCK_W-1:0] cfg_data;
	logic                         capture_valid;
	logic                         capture_ready;
	pcra_pkg::capture_word_t      capture;
	logic                         report_valid;
	logic                         report_ready;
	pcra_pkg::report_word_t       report;

	pcra_pkg::report_word_t       pending_report [$];
	logic [pcra_pkg::CLOCK_W-1:0] model_clock_hz;
	int                           mismatch_count = 0;
	int                           burst_left = 0;

	capture_case_t directed_cases [N_DIRECTED] = '{
		'{CHECK_TYPED,   28'd72000000,  16'd1,      16'd0,      32'd72000000,  32'd0},
		'{CHECK_TYPED,   28'd72000000,  16'd65535,  16'd65535,  32'd1098,      32'd100},
		'{CHECK_SILENT,  28'd72000000,  16'd0,      16'd1234,   32'd0,         32'd0},
		'{CHECK_SILENT,  28'd72000000,  16'd0,      16'd0,      32'd0,         32'd0},
		'{CHECK_TYPED,   28'd72000000,  16'd100,    16'd50,     32'd720000,    32'd50},
		'{CHECK_TYPED,   28'd72000000,  16'd2,      16'd3,      32'd36000000,  32'd100},
		'{CHECK_TYPED,   28'd72000000,  16'd7,      16'd7,      32'd10285714,  32'd100},
		'{CHECK_PREDICT, 28'd72000000,  16'd3,      16'd1,      32'd0,         32'd0},
		'{CHECK_PREDICT, 28'd72000000,  16'd65535,  16'd65534,  32'd0,         32'd0},
		'{CHECK_PREDICT, 28'd72000000,  16'hAAAA,   16'h5555,   32'd0,         32'd0},
		'{CHECK_PREDICT, 28'd72000000,  16'h5555,   16'hAAAA,   32'd0,         32'd0},
		'{CHECK_PREDICT, 28'd72000000,  16'd65535,  16'd0,      32'd0,         32'd0},
		'{CHECK_TYPED,   28'd0,         16'd1,      16'd1,      32'd0,         32'd100},
		'{CHECK_PREDICT, 28'd0,         16'd65535,  16'd100,    32'd0,         32'd0},
		'{CHECK_SILENT,  28'd0,         16'd0,      16'd7,      32'd0,         32'd0},
		'{CHECK_TYPED,   28'd1,         16'd1,      16'd0,      32'd1,         32'd0},
		'{CHECK_TYPED,   28'd1,         16'd2,      16'd1,      32'd0,         32'd50},
		'{CHECK_TYPED,   28'd200000000, 16'd1,      16'd65535,  32'd200000000, 32'd100},
		'{CHECK_PREDICT, 28'd200000000, 16'd3,      16'd2,      32'd0,         32'd0},
		'{CHECK_TYPED,   28'hFFFFFFF,   16'd1,      16'd0,      32'd268435455, 32'd0},
		'{CHECK_PREDICT, 28'hFFFFFFF,   16'd65535,  16'd32767,  32'd0,         32'd0},
		'{CHECK_PREDICT, 28'd72000000,  16'd1000,   16'd999,    32'd0,         32'd0}
	};

	pwm_capture_report_ascii_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.capture_valid (capture_valid),
		.capture_ready (capture_ready),
		.capture       (capture),
		.report_valid  (report_valid),
		.report_ready  (report_ready),
		.report        (report)
	);

	// Queue the decimal digits of one value, most significant first, then its newline
	function automatic void queue_decimal(logic [31:0] value, logic kind, logic last);
		logic [3:0]             digits [pcra_pkg::MAX_DIGITS];
		logic [31:0]            rest;
		int                     count;
		int                     i;
		pcra_pkg::report_word_t w;
		rest  = value;
		count = 0;
		if (rest == 0) begin
			digits[0] = 4'd0;
			count     = 1;
		end
		while (rest != 0 && count < pcra_pkg::MAX_DIGITS) begin
			digits[count] = 4'(rest % 10);
			rest          = rest / 10;
			count++;
		end
		for (i = count - 1; i >= 0; i--) begin
			w.ascii_char = pcra_pkg::DIGIT_BASE + 8'(digits[i]);
			w.value_kind = kind;
			w.last_byte  = 1'b0;
			pending_report.push_back(w);
		end
		w.ascii_char = pcra_pkg::NEWLINE_CHAR;
		w.value_kind = kind;
		w.last_byte  = last;
		pending_report.push_back(w);
	endfunction

	// Work out the report bytes of one capture word; a zero period reports nothing
	function automatic void predict_report_bytes(pcra_pkg::capture_word_t w);
		logic [31:0] period;
		logic [31:0] high;
		logic [31:0] freq;
		logic [31:0] duty;
		period = 32'(w.period_count);
		high   = 32'(w.high_count);
		if (period == 0)
			return;
		freq = 32'(model_clock_hz) / period;
		if (high >= period)
			duty = 32'(pcra_pkg::DUTY_FULL);
		else
			duty = (high * 32'(pcra_pkg::DUTY_FULL)) / period;
		queue_decimal(freq, pcra_pkg::KIND_FREQ, 1'b0);
		queue_decimal(duty, pcra_pkg::KIND_DUTY, 1'b1);
	endfunction

	// Mostly well-formed captures, some with high time past the period, a few zero periods
	function automatic pcra_pkg::capture_word_t random_capture();
		pcra_pkg::capture_word_t w;
		int                      sel;
		int                      p;
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			p = 0;
			w.high_count = 16'($urandom);
		end else if (sel < 35) begin
			p = $urandom_range(1, 20);
			w.high_count = 16'($urandom_range(0, p + 2));
		end else if (sel < 75) begin
			p = $urandom_range(1, 65535);
			w.high_count = 16'($urandom_range(0, p));
		end else if (sel < 90) begin
			p = $urandom_range(1, 65535);
			w.high_count = 16'($urandom);
		end else begin
			case ($urandom_range(0, 2))
				0: p = 1;
				1: p = 65535;
				default: p = 32768;
			endcase
			case ($urandom_range(0, 2))
				0: w.high_count = 16'd0;
				1: w.high_count = 16'hFFFF;
				default: w.high_count = 16'(p - 1);
			endcase
		end
		w.period_count = 16'(p);
		return w;
	endfunction

	// Offer one capture word and hold it until taken
	task automatic send_capture(pcra_pkg::capture_word_t w);
		@(negedge clk);
		capture_valid <= 1'b1;
		capture       <= w;
		do
			@(posedge clk);
		while (capture_ready !== 1'b1);
	endtask

	// Bursts of random length with random gaps, sometimes long stretches without gaps
	task automatic pace_sender();
		int gap;
		int sel;
		if (burst_left == 0) begin
			sel = $urandom_range(0, 9);
			if (sel < 3)
				gap = 0;
			else if (sel < 8)
				gap = $urandom_range(1, 6);
			else
				gap = $urandom_range(10, 40);
			burst_left = $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				capture_valid <= 1'b0;
			end
		end
		burst_left--;
	endtask

	// Drop valid and hold off until every expected word has arrived
	task automatic drain_reports();
		@(negedge clk);
		capture_valid <= 1'b0;
		while (pending_report.size() != 0)
			@(posedge clk);
	endtask

	// Wait for the block to settle, then write clock_hz
	task automatic write_clock(logic [pcra_pkg::CLOCK_W-1:0] hz);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= hz;
		@(negedge clk);
		cfg_we   <= 1'b0;
		model_clock_hz = hz;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls on its own pattern, switching mode after spans of random length
	initial begin
		int stall_mode;
		int span;
		int tick;
		report_ready = 1'b0;
		tick = 0;
		forever begin
			stall_mode = $urandom_range(0, 3);
			span       = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (stall_mode)
					0: report_ready <= 1'b1;
					1: report_ready <= 1'($urandom_range(0, 1));
					2: report_ready <= ($urandom_range(0, 4) == 0);
					default: report_ready <= (tick % 4 != 3);
				endcase
			end
		end
	end

	// Compare each accepted report word with the oldest expectation
	always @(posedge clk) begin
		pcra_pkg::report_word_t want;
		if (arst_n === 1'b1 && report_valid === 1'b1 && report_ready === 1'b1) begin
			if (pending_report.size() == 0) begin
				$error("unexpected report word: char %0d kind %0d last %0d",
					report.ascii_char, report.value_kind, report.last_byte);
				mismatch_count++;
			end else begin
				want = pending_report.pop_front();
				if (report.ascii_char !== want.ascii_char) begin
					$error("ascii_char: expected %0d, got %0d", want.ascii_char, report.ascii_char);
					mismatch_count++;
				end
				if (report.value_kind !== want.value_kind) begin
					$error("value_kind: expected %0d, got %0d", want.value_kind, report.value_kind);
					mismatch_count++;
				end
				if (report.last_byte !== want.last_byte) begin
					$error("last_byte: expected %0d, got %0d", want.last_byte, report.last_byte);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus: directed table, then random phases over several clock settings
	initial begin
		capture_case_t                row;
		pcra_pkg::capture_word_t      w;
		logic [pcra_pkg::CLOCK_W-1:0] phase_clock;
		int                           sent;
		int                           i;
		int                           phase;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_data       = '0;
		capture_valid  = 1'b0;
		capture        = '0;
		model_clock_hz = pcra_pkg::CLOCK_HZ_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table, changing clock_hz only when idle
		for (i = 0; i < N_DIRECTED; i++) begin
			row = directed_cases[i];
			if (row.clock_hz != model_clock_hz) begin
				drain_reports();
				write_clock(row.clock_hz);
			end
			w.period_count = row.period;
			w.high_count   = row.high;
			pace_sender();
			send_capture(w);
			case (row.mode)
				CHECK_TYPED: begin
					queue_decimal(row.freq, pcra_pkg::KIND_FREQ, 1'b0);
					queue_decimal(row.duty, pcra_pkg::KIND_DUTY, 1'b1);
				end
				CHECK_PREDICT: predict_report_bytes(w);
				default: ;
			endcase
		end

		// Random phases: reset value, extremes, then two random settings
		for (phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0: phase_clock = pcra_pkg::CLOCK_HZ_RESET;
				1: phase_clock = '0;
				2: phase_clock = pcra_pkg::CLOCK_W'(1);
				3: phase_clock = pcra_pkg::CLOCK_W'(200000000);
				4: phase_clock = '1;
				5: phase_clock = pcra_pkg::CLOCK_W'($urandom_range(1, 200000000));
				default: phase_clock = pcra_pkg::CLOCK_W'($urandom);
			endcase
			drain_reports();
			write_clock(phase_clock);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				w = random_capture();
				pace_sender();
				send_capture(w);
				predict_report_bytes(w);
				if (w.period_count != 0) begin
					sent++;
					// Hold the sender until the report backlog has drained
					if (sent == DRAIN_POINT)
						drain_reports();
				end
			end
		end

		drain_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Give up well beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ pwm_capture_report_ascii_unit.f @@
design/pcra_pkg.sv
design/pcra_front.sv
design/pcra_queue.sv
design/pcra_back.sv
design/pwm_capture_report_ascii_unit.sv
design/pcra_checker.sv
tb/tb_pwm_capture_report_ascii_unit.sv
